/* rtl/pts_pkg.sv */
// package for the priority task scheduler: codes, slot entry and word types
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int NUM_SEMS  = 8;
    localparam int ID_WIDTH  = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int SEM_W     = $clog2(NUM_SEMS);
    localparam int STAMP_W   = 16;

    localparam logic [2:0] K_CREATE   = 3'd0;
    localparam logic [2:0] K_FORK     = 3'd1;
    localparam logic [2:0] K_KILL     = 3'd2;
    localparam logic [2:0] K_KILL_RUN = 3'd3;
    localparam logic [2:0] K_QUANTUM  = 3'd4;
    localparam logic [2:0] K_BLOCK    = 3'd5;
    localparam logic [2:0] K_UNBLOCK  = 3'd6;
    localparam logic [2:0] K_INFO     = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_RUN    = 3'd4;
    localparam logic [2:0] ST_NONE_BLK  = 3'd5;

    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;

    localparam logic [1:0] LVL_BAD = 2'd3;

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        logic [1:0]          level;
        logic [1:0]          mode;
        logic [STAMP_W-1:0]  stamp;
        logic [SEM_W-1:0]    sem;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  priority_req;
        logic [15:0] pid;
        logic [2:0]  sem_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_pid;
        logic        running_valid;
        logic [15:0] running_pid;
        logic [1:0]  info_level;
        logic [1:0]  info_state;
    } t_out;

    // strictly better: higher level (lower code), then older
    function automatic logic better(input logic [1:0] la, input logic [STAMP_W-1:0] aa,
                                    input logic [1:0] lb, input logic [STAMP_W-1:0] ab);
        better = (la < lb) || ((la == lb) && (aa > ab));
    endfunction

endpackage

/* rtl/pts_slot_ram.sv */
// slot table memory: one write port, one registered read port
module pts_slot_ram
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_entry            o_rdata
);
    t_entry r_mem [MAX_TASKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/priority_task_scheduler_core.sv */
// top level of the three-level strict priority task scheduler
//
// one event word is taken when start is high and busy is low. every event
// sweeps the sixteen slot table in memory, one slot read per cycle, then
// writes back at most two entries. the result word is shown on o_word
// with o_done, which is high for a single cycle; the receiver cannot
// stall it, so it must take it then. busy is low again in the strobe cycle
// and a new event may be started there.
module priority_task_scheduler_core
    import pts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_word,
    output logic busy,
    output logic o_done,
    output t_out o_word
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_WR2  = 2'd3;

    logic [1:0]          r_state;
    t_in                 r_in;
    logic [SLOT_W:0]     r_cnt;
    logic                r_rd_vld;
    logic [SLOT_W-1:0]   r_rd_idx;
    logic [MAX_TASKS-1:0] r_used;
    logic [ID_WIDTH-1:0] r_next_id;
    logic [STAMP_W-1:0]  r_ctr;
    logic [STAMP_W-1:0]  r_sel_ctr;
    logic                r_run_v;
    logic [SLOT_W-1:0]   r_run_slot;
    logic [ID_WIDTH-1:0] r_run_id;
    logic [1:0]          r_run_lvl;

    // sweep captures
    t_entry              r_run_e;
    logic                r_fnd_v;
    logic [SLOT_W-1:0]   r_fnd_i;
    t_entry              r_fnd_e;
    logic                r_bst_v;
    logic [SLOT_W-1:0]   r_bst_i;
    t_entry              r_bst_e;
    logic [STAMP_W-1:0]  r_bst_age;
    logic                r_blk_v;
    logic [SLOT_W-1:0]   r_blk_i;
    t_entry              r_blk_e;
    logic [STAMP_W-1:0]  r_blk_age;

    // second write
    logic [SLOT_W-1:0]   r_w2_addr;
    t_entry              r_w2_data;

    logic                r_done;
    t_out                r_out;

    t_entry              rdata;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    t_entry              mem_wdata;

    pts_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cnt[SLOT_W-1:0]),
        .o_rdata (rdata)
    );

    // lowest free slot
    logic              free_v;
    logic [SLOT_W-1:0] free_i;
    always_comb begin
        free_v = 1'b0;
        free_i = '0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_v = 1'b1;
                free_i = SLOT_W'(k);
            end
        end
    end

    // sweep compare terms
    logic [STAMP_W-1:0] age_sel;
    logic [STAMP_W-1:0] age_blk;
    logic               sc_used;
    logic               sc_match;
    logic               sc_excl;
    assign age_sel  = r_sel_ctr - rdata.stamp;
    assign age_blk  = r_ctr - rdata.stamp;
    assign sc_used  = r_used[r_rd_idx];
    assign sc_match = sc_used && (rdata.id == r_in.pid) && !r_fnd_v;
    assign sc_excl  = sc_match && (r_in.kind == K_KILL);

    // evaluation of the event once the sweep is complete
    t_out                n_out;
    logic                w1_en;
    logic [SLOT_W-1:0]   w1_addr;
    t_entry              w1_data;
    logic                n_w2_en;
    logic [SLOT_W-1:0]   n_w2_addr;
    t_entry              n_w2_data;
    logic                n_run_v;
    logic [SLOT_W-1:0]   n_run_slot;
    logic [ID_WIDTH-1:0] n_run_id;
    logic [1:0]          n_run_lvl;
    logic [STAMP_W-1:0]  n_ctr;
    logic [ID_WIDTH-1:0] n_next_id;
    logic                set_en;
    logic [SLOT_W-1:0]   set_i;
    logic                clr_en;
    logic [SLOT_W-1:0]   clr_i;
    logic [1:0]          c_lvl;
    t_entry              e_tmp;
    t_entry              e_bst;
    logic                pick_blk;

    always_comb begin
        n_out      = '0;
        w1_en      = 1'b0;
        w1_addr    = '0;
        w1_data    = r_bst_e;
        n_w2_en    = 1'b0;
        n_w2_addr  = r_bst_i;
        n_w2_data  = r_bst_e;
        n_run_v    = r_run_v;
        n_run_slot = r_run_slot;
        n_run_id   = r_run_id;
        n_run_lvl  = r_run_lvl;
        n_ctr      = r_ctr;
        n_next_id  = r_next_id;
        set_en     = 1'b0;
        set_i      = free_i;
        clr_en     = 1'b0;
        clr_i      = r_run_slot;
        c_lvl      = (r_in.kind == K_CREATE) ? r_in.priority_req : r_run_lvl;
        e_tmp      = r_blk_e;
        e_bst      = r_bst_e;
        e_bst.mode = MODE_RUN;
        pick_blk   = 1'b0;
        case (r_in.kind)
            K_CREATE, K_FORK: begin
                if (r_in.kind == K_FORK && !r_run_v) begin
                    n_out.status = ST_NO_RUN;
                end else if (!free_v) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_next_id = r_next_id + 1'b1;
                    if (c_lvl == LVL_BAD) begin
                        n_out.status = ST_BAD_PRIO;
                    end else begin
                        e_tmp.id    = r_next_id;
                        e_tmp.level = c_lvl;
                        e_tmp.mode  = r_run_v ? MODE_READY : MODE_RUN;
                        e_tmp.stamp = r_ctr;
                        e_tmp.sem   = '0;
                        w1_en   = 1'b1;
                        w1_addr = free_i;
                        w1_data = e_tmp;
                        set_en  = 1'b1;
                        n_ctr   = r_ctr + 1'b1;
                        n_out.result_pid = r_next_id;
                        if (!r_run_v) begin
                            n_run_v    = 1'b1;
                            n_run_slot = free_i;
                            n_run_id   = r_next_id;
                            n_run_lvl  = c_lvl;
                        end
                    end
                end
            end
            K_KILL, K_KILL_RUN: begin
                if (r_in.kind == K_KILL && !r_fnd_v) begin
                    n_out.status = ST_NOT_FOUND;
                end else if (r_in.kind == K_KILL_RUN && !r_run_v) begin
                    n_out.status = ST_NO_RUN;
                end else begin
                    clr_en = 1'b1;
                    if (r_in.kind == K_KILL) begin
                        clr_i = r_fnd_i;
                        n_out.result_pid = r_fnd_e.id;
                        n_run_v = r_run_v && (r_run_slot != r_fnd_i);
                    end else begin
                        n_out.result_pid = r_run_id;
                        n_run_v = 1'b0;
                    end
                    // the victim is never in the ready set here
                    if (!n_run_v && r_bst_v) begin
                        w1_en      = 1'b1;
                        w1_addr    = r_bst_i;
                        w1_data    = e_bst;
                        n_run_v    = 1'b1;
                        n_run_slot = r_bst_i;
                        n_run_id   = r_bst_e.id;
                        n_run_lvl  = r_bst_e.level;
                    end
                end
            end
            K_QUANTUM: begin
                if (!r_run_v) begin
                    n_out.status = ST_NO_RUN;
                end else if (r_bst_v) begin
                    e_tmp      = r_run_e;
                    e_tmp.mode = MODE_READY;
                    w1_en      = 1'b1;
                    w1_addr    = r_run_slot;
                    w1_data    = e_tmp;
                    n_w2_en    = 1'b1;
                    n_w2_data  = e_bst;
                    n_run_slot = r_bst_i;
                    n_run_id   = r_bst_e.id;
                    n_run_lvl  = r_bst_e.level;
                end
            end
            K_BLOCK: begin
                if (!r_run_v) begin
                    n_out.status = ST_NO_RUN;
                end else begin
                    n_out.result_pid = r_run_id;
                    e_tmp       = r_run_e;
                    e_tmp.mode  = MODE_BLOCK;
                    e_tmp.sem   = r_in.sem_id[SEM_W-1:0];
                    e_tmp.stamp = r_ctr;
                    w1_en   = 1'b1;
                    w1_addr = r_run_slot;
                    w1_data = e_tmp;
                    n_ctr   = r_ctr + 1'b1;
                    n_run_v = 1'b0;
                    if (r_bst_v) begin
                        n_w2_en    = 1'b1;
                        n_w2_data  = e_bst;
                        n_run_v    = 1'b1;
                        n_run_slot = r_bst_i;
                        n_run_id   = r_bst_e.id;
                        n_run_lvl  = r_bst_e.level;
                    end
                end
            end
            K_UNBLOCK: begin
                if (!r_blk_v) begin
                    n_out.status = ST_NONE_BLK;
                end else begin
                    n_out.result_pid = r_blk_e.id;
                    e_tmp.mode  = MODE_READY;
                    e_tmp.stamp = r_ctr;
                    n_ctr   = r_ctr + 1'b1;
                    w1_en   = 1'b1;
                    w1_addr = r_blk_i;
                    if (!r_run_v) begin
                        // the woken task has age one at selection time
                        pick_blk = !r_bst_v
                            || better(r_blk_e.level, STAMP_W'(1), r_bst_e.level, r_bst_age)
                            || (!better(r_bst_e.level, r_bst_age, r_blk_e.level, STAMP_W'(1))
                                && (r_blk_i < r_bst_i));
                        if (pick_blk) begin
                            e_tmp.mode = MODE_RUN;
                            n_run_v    = 1'b1;
                            n_run_slot = r_blk_i;
                            n_run_id   = r_blk_e.id;
                            n_run_lvl  = r_blk_e.level;
                        end else begin
                            n_w2_en    = 1'b1;
                            n_w2_data  = e_bst;
                            n_run_v    = 1'b1;
                            n_run_slot = r_bst_i;
                            n_run_id   = r_bst_e.id;
                            n_run_lvl  = r_bst_e.level;
                        end
                    end
                    w1_data = e_tmp;
                end
            end
            default: begin
                if (!r_fnd_v) begin
                    n_out.status = ST_NOT_FOUND;
                end else begin
                    n_out.result_pid = r_fnd_e.id;
                    n_out.info_level = r_fnd_e.level;
                    n_out.info_state = r_fnd_e.mode;
                end
            end
        endcase
        n_out.running_valid = n_run_v;
        n_out.running_pid   = n_run_v ? n_run_id : '0;
    end

    assign mem_we    = (r_state == S_EVAL) ? w1_en : (r_state == S_WR2);
    assign mem_waddr = (r_state == S_EVAL) ? w1_addr : r_w2_addr;
    assign mem_wdata = (r_state == S_EVAL) ? w1_data : r_w2_data;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_next_id <= ID_WIDTH'(1);
            r_ctr     <= '0;
            r_run_v   <= 1'b0;
            r_run_slot <= '0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state  <= S_SCAN;
                        r_cnt    <= '0;
                        r_rd_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= !r_cnt[SLOT_W];
                    if (!r_cnt[SLOT_W]) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_rd_vld && r_rd_idx == SLOT_W'(MAX_TASKS - 1)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_run_v    <= n_run_v;
                    r_run_slot <= n_run_slot;
                    r_ctr      <= n_ctr;
                    r_next_id  <= n_next_id;
                    if (set_en) begin
                        r_used[set_i] <= 1'b1;
                    end
                    if (clr_en) begin
                        r_used[clr_i] <= 1'b0;
                    end
                    if (n_w2_en) begin
                        r_state <= S_WR2;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                S_WR2: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[SLOT_W-1:0];
        if (r_state == S_IDLE && start) begin
            r_in    <= i_word;
            r_fnd_v <= 1'b0;
            r_bst_v <= 1'b0;
            r_blk_v <= 1'b0;
            // selection after block or unblock sees the advanced counter
            r_sel_ctr <= (i_word.kind == K_BLOCK || i_word.kind == K_UNBLOCK)
                         ? r_ctr + 1'b1 : r_ctr;
        end
        if (r_state == S_SCAN && r_rd_vld) begin
            if (sc_used && r_run_v && r_rd_idx == r_run_slot) begin
                r_run_e <= rdata;
            end
            if (sc_match) begin
                r_fnd_v <= 1'b1;
                r_fnd_i <= r_rd_idx;
                r_fnd_e <= rdata;
            end
            if (sc_used && !sc_excl && rdata.mode == MODE_READY
                && (!r_bst_v || better(rdata.level, age_sel, r_bst_e.level, r_bst_age))) begin
                r_bst_v   <= 1'b1;
                r_bst_i   <= r_rd_idx;
                r_bst_e   <= rdata;
                r_bst_age <= age_sel;
            end
            if (sc_used && rdata.mode == MODE_BLOCK && rdata.sem == r_in.sem_id[SEM_W-1:0]
                && (!r_blk_v || age_blk > r_blk_age)) begin
                r_blk_v   <= 1'b1;
                r_blk_i   <= r_rd_idx;
                r_blk_e   <= rdata;
                r_blk_age <= age_blk;
            end
        end
        if (r_state == S_EVAL) begin
            r_out     <= n_out;
            r_run_id  <= n_run_id;
            r_run_lvl <= n_run_lvl;
            r_w2_addr <= n_w2_addr;
            r_w2_data <= n_w2_data;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_word = r_out;

    // the running slot always points at a used slot
    a_run_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_v |-> r_used[r_run_slot])
        else $error("running slot not in use");

    // an accepted event makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not start a sweep");

    // the result strobe comes only when the sequencer has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && ($past(r_state) == S_EVAL || $past(r_state) == S_WR2)))
        else $error("result strobe outside of completion");
endmodule
